// ===== sv/tst_pkg.sv =====
package tst_pkg;

   localparam int SLOTS = 4096;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int LINK_W = SLOT_W + 1;
   localparam int CNT_W = 16;
   localparam int ID_W = 64;

   localparam logic [LINK_W-1:0] NO_LINK = {LINK_W{1'b1}};
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   localparam logic [3:0] OP_ALLOC = 4'd0;
   localparam logic [3:0] OP_ALLOC_ID = 4'd1;
   localparam logic [3:0] OP_RELEASE = 4'd2;
   localparam logic [3:0] OP_SEARCH = 4'd3;
   localparam logic [3:0] OP_PROBE = 4'd4;
   localparam logic [3:0] OP_SUCC = 4'd5;
   localparam logic [3:0] OP_IMP_BEGIN = 4'd6;
   localparam logic [3:0] OP_IMP_END = 4'd7;
   localparam logic [3:0] OP_SET_ID = 4'd8;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_FULL = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_NOT_ACTIVE = 3'd3;
   localparam logic [2:0] ST_NO_NEXT = 3'd4;

   typedef struct packed {
      logic [3:0] op;
      logic implicit_flag;
      logic [11:0] slot_in;
      logic [63:0] id_in;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [11:0] slot_out;
      logic [63:0] id_out;
      logic implicit_out;
      logic [63:0] next_id;
      logic [15:0] active_count;
      logic [15:0] implicit_count;
      logic [63:0] oldest_id;
   } rsp_type;

endpackage

// ===== sv/transaction_slot_table.sv =====
// Implicit begin/end, set id, unused ops and a full table answer without a memory read;
// probe and inactive slots read the slot; alloc appends the free head to the list; release
// unlinks the slot, reading the new head's id when the head goes and a successor remains;
// successor reads the next slot; search walks from the head, answering at once on an empty
// list. One word at a time, a new word can be taken in the strobe cycle. The receiver cannot
// stall. Reset (synchronous, active high) links all SLOTS slots as free, busy high.
module transaction_slot_table
   import tst_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  req_type req_data,
   output logic rsp_valid,
   output rsp_type rsp_data
);

   localparam logic [3:0] S_INIT = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_RD1 = 4'd2;
   localparam logic [3:0] S_EX1 = 4'd3;
   localparam logic [3:0] S_EX2 = 4'd4;
   localparam logic [3:0] S_EX3 = 4'd5;
   localparam logic [3:0] S_WALK = 4'd6;
   localparam logic [3:0] S_WCHK = 4'd7;
   localparam logic [3:0] S_HEAD = 4'd8;
   localparam logic [3:0] S_HEADW = 4'd9;
   localparam logic [3:0] S_DONE = 4'd10;

   // memories: next, prev, id, flags {active, implicit}
   logic [LINK_W-1:0] nxt_mem [SLOTS];
   logic [LINK_W-1:0] prv_mem [SLOTS];
   logic [ID_W-1:0] id_mem [SLOTS];
   logic [1:0] flg_mem [SLOTS];

   logic [SLOT_W-1:0] raddr;
   logic [LINK_W-1:0] nxt_rd, prv_rd;
   logic [ID_W-1:0] id_rd;
   logic [1:0] flg_rd;

   logic nxt_we, prv_we, id_we, flg_we;
   logic [SLOT_W-1:0] nxt_wa, prv_wa, id_wa, flg_wa;
   logic [LINK_W-1:0] nxt_wd, prv_wd;
   logic [ID_W-1:0] id_wd;
   logic [1:0] flg_wd;

   always_ff @(posedge clock) begin
      if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
      if (prv_we) prv_mem[prv_wa] <= prv_wd;
      if (id_we) id_mem[id_wa] <= id_wd;
      if (flg_we) flg_mem[flg_wa] <= flg_wd;
      nxt_rd <= nxt_mem[raddr];
      prv_rd <= prv_mem[raddr];
      id_rd <= id_mem[raddr];
      flg_rd <= flg_mem[raddr];
   end

   logic [3:0] state_ff, state_in;
   req_type req_ff, req_in;
   logic [LINK_W-1:0] free_ff, free_in, head_ff, head_in, tail_ff, tail_in;
   logic [ID_W-1:0] idc_ff, idc_in, oldest_ff, oldest_in;
   logic [CNT_W-1:0] act_ff, act_in, imp_ff, imp_in;
   logic [SLOT_W:0] cnt_ff, cnt_in;
   logic [LINK_W-1:0] cur_ff, cur_in, ln_ff, ln_in, lp_ff, lp_in;
   logic [2:0] st_ff, st_in;
   logic [SLOT_W-1:0] so_ff, so_in;
   logic [ID_W-1:0] io_ff, io_in;
   logic io_imp_ff, io_imp_in;
   logic rv_ff, rv_in;

   function automatic logic [CNT_W-1:0] up(input logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? c : c + 1'b1;
   endfunction
   function automatic logic [CNT_W-1:0] dn(input logic [CNT_W-1:0] c);
      return (c == '0) ? c : c - 1'b1;
   endfunction

   always_comb begin
      state_in = state_ff; req_in = req_ff;
      free_in = free_ff; head_in = head_ff; tail_in = tail_ff;
      idc_in = idc_ff; oldest_in = oldest_ff; act_in = act_ff; imp_in = imp_ff;
      cnt_in = cnt_ff; cur_in = cur_ff; ln_in = ln_ff; lp_in = lp_ff;
      st_in = st_ff; so_in = so_ff; io_in = io_ff; io_imp_in = io_imp_ff;
      rv_in = 1'b0;
      raddr = cur_ff[SLOT_W-1:0];
      nxt_we = 1'b0; prv_we = 1'b0; id_we = 1'b0; flg_we = 1'b0;
      nxt_wa = cur_ff[SLOT_W-1:0]; prv_wa = cur_ff[SLOT_W-1:0];
      id_wa = cur_ff[SLOT_W-1:0]; flg_wa = cur_ff[SLOT_W-1:0];
      nxt_wd = '0; prv_wd = NO_LINK; id_wd = '0; flg_wd = '0;
      unique case (state_ff)
         S_INIT: begin
            nxt_we = 1'b1; prv_we = 1'b1; flg_we = 1'b1;
            nxt_wa = cnt_ff[SLOT_W-1:0]; prv_wa = cnt_ff[SLOT_W-1:0];
            flg_wa = cnt_ff[SLOT_W-1:0];
            nxt_wd = (cnt_ff == (SLOT_W+1)'(SLOTS-1)) ? NO_LINK
                     : LINK_W'(cnt_ff + 1'b1);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (SLOT_W+1)'(SLOTS-1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               st_in = ST_OK; so_in = '0; io_in = '0; io_imp_in = 1'b0;
               cnt_in = '0;
               unique case (req_data.op) inside
                  OP_ALLOC, OP_ALLOC_ID: begin
                     if (free_ff[SLOT_W]) begin
                        st_in = ST_FULL; state_in = S_DONE;
                     end else begin
                        cur_in = free_ff; state_in = S_RD1;
                     end
                  end
                  OP_RELEASE, OP_PROBE, OP_SUCC: begin
                     cur_in = {1'b0, req_data.slot_in[SLOT_W-1:0]};
                     state_in = S_RD1;
                  end
                  OP_SEARCH: begin
                     cur_in = head_ff; st_in = ST_NOT_FOUND;
                     state_in = head_ff[SLOT_W] ? S_DONE : S_WALK;
                  end
                  OP_IMP_BEGIN: begin
                     io_in = idc_ff; io_imp_in = 1'b1; idc_in = idc_ff + 1'b1;
                     imp_in = up(imp_ff); act_in = up(act_ff); state_in = S_DONE;
                  end
                  OP_IMP_END: begin
                     imp_in = dn(imp_ff); act_in = dn(act_ff); state_in = S_DONE;
                  end
                  OP_SET_ID: begin
                     idc_in = req_data.id_in; state_in = S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_RD1: state_in = S_EX1;   // read of cur in flight
         S_EX1: begin
            ln_in = nxt_rd; lp_in = prv_rd;
            unique case (req_ff.op) inside
               OP_ALLOC, OP_ALLOC_ID: begin
                  free_in = nxt_rd;
                  nxt_we = 1'b1; nxt_wd = NO_LINK;
                  prv_we = 1'b1; prv_wd = tail_ff;
                  id_we = 1'b1;
                  flg_we = 1'b1;
                  if (req_ff.op == OP_ALLOC) begin
                     id_wd = idc_ff; idc_in = idc_ff + 1'b1;
                     flg_wd = {1'b1, req_ff.implicit_flag};
                     if (req_ff.implicit_flag) imp_in = up(imp_ff);
                     io_imp_in = req_ff.implicit_flag;
                  end else begin
                     id_wd = req_ff.id_in; idc_in = req_ff.id_in + 1'b1;
                     flg_wd = 2'b10;
                  end
                  io_in = id_wd;
                  act_in = up(act_ff);
                  so_in = cur_ff[SLOT_W-1:0];
                  tail_in = cur_ff;
                  if (tail_ff[SLOT_W]) begin
                     head_in = cur_ff; oldest_in = id_wd; state_in = S_DONE;
                  end else state_in = S_EX2;
               end
               default: begin
                  if ({1'b0, req_ff.slot_in} >= LINK_W'(SLOTS) || !flg_rd[1]) begin
                     st_in = ST_NOT_ACTIVE; state_in = S_DONE;
                  end else if (req_ff.op == OP_PROBE) begin
                     so_in = cur_ff[SLOT_W-1:0]; io_in = id_rd;
                     io_imp_in = flg_rd[0]; state_in = S_DONE;
                  end else if (req_ff.op == OP_SUCC) begin
                     if (nxt_rd[SLOT_W]) begin
                        st_in = ST_NO_NEXT; state_in = S_DONE;
                     end else begin
                        cur_in = nxt_rd; state_in = S_HEADW;
                     end
                  end else begin
                     // release
                     so_in = cur_ff[SLOT_W-1:0]; io_in = id_rd;
                     io_imp_in = flg_rd[0];
                     nxt_we = 1'b1; nxt_wd = free_ff;
                     prv_we = 1'b1; prv_wd = NO_LINK;
                     flg_we = 1'b1; flg_wd = 2'b00;
                     free_in = cur_ff;
                     if (flg_rd[0]) imp_in = dn(imp_ff);
                     act_in = dn(act_ff);
                     state_in = S_EX2;
                  end
               end
            endcase
         end
         S_EX2: begin
            if (req_ff.op == OP_RELEASE) begin
               if (lp_ff[SLOT_W]) head_in = ln_ff;
               else begin
                  nxt_we = 1'b1; nxt_wa = lp_ff[SLOT_W-1:0]; nxt_wd = ln_ff;
               end
               if (ln_ff[SLOT_W]) tail_in = lp_ff;
               else begin
                  prv_we = 1'b1; prv_wa = ln_ff[SLOT_W-1:0]; prv_wd = lp_ff;
               end
               if (lp_ff[SLOT_W]) begin
                  if (ln_ff[SLOT_W]) begin
                     oldest_in = '0; state_in = S_DONE;
                  end else begin
                     cur_in = ln_ff; state_in = S_HEAD;
                  end
               end else state_in = S_DONE;
            end else begin
               // append: old tail (held in lp) gets next = new slot
               nxt_we = 1'b1; nxt_wa = lp_ff[SLOT_W-1:0]; nxt_wd = cur_ff;
               state_in = S_DONE;
            end
         end
         S_HEAD: state_in = S_EX3;
         S_EX3: begin
            oldest_in = id_rd; state_in = S_DONE;
         end
         S_HEADW: state_in = S_WCHK;   // successor read
         S_WALK: state_in = S_WCHK;
         S_WCHK: begin
            if (req_ff.op == OP_SUCC) begin
               so_in = cur_ff[SLOT_W-1:0]; io_in = id_rd; io_imp_in = flg_rd[0];
               state_in = S_DONE;
            end else if (id_rd == req_ff.id_in) begin
               st_in = ST_OK; so_in = cur_ff[SLOT_W-1:0]; io_in = id_rd;
               io_imp_in = flg_rd[0]; state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               cur_in = nxt_rd;
               if (nxt_rd[SLOT_W] || cnt_ff == (SLOT_W+1)'(SLOTS-1)) state_in = S_DONE;
               else state_in = S_WALK;
            end
         end
         S_DONE: begin
            rv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT; cnt_ff <= '0;
         free_ff <= '0; head_ff <= NO_LINK; tail_ff <= NO_LINK;
         idc_ff <= 64'd1; oldest_ff <= '0; act_ff <= '0; imp_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in;
         free_ff <= free_in; head_ff <= head_in; tail_ff <= tail_in;
         idc_ff <= idc_in; oldest_ff <= oldest_in; act_ff <= act_in;
         imp_ff <= imp_in; rv_ff <= rv_in;
      end
      req_ff <= req_in; cur_ff <= cur_in; ln_ff <= ln_in;
      lp_ff <= (state_ff == S_EX1 && (req_ff.op == OP_ALLOC || req_ff.op == OP_ALLOC_ID))
               ? tail_ff : lp_in;
      st_ff <= st_in; so_ff <= so_in; io_ff <= io_in; io_imp_ff <= io_imp_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   always_comb begin
      rsp_data.status = st_ff;
      rsp_data.slot_out = 12'(so_ff);
      rsp_data.id_out = io_ff;
      rsp_data.implicit_out = io_imp_ff;
      rsp_data.next_id = idc_ff;
      rsp_data.active_count = act_ff;
      rsp_data.implicit_count = imp_ff;
      rsp_data.oldest_id = oldest_ff;
   end

endmodule

// ===== sv/tst_checker.sv =====
module tst_checker
   import tst_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input req_type req_data,
   input logic rsp_valid,
   input rsp_type rsp_data
);

   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("rsp strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("word accepted without going busy");

   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while still busy");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_NO_NEXT) else $error("bad status");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> rsp_data.id_out == '0)
      else $error("error response carries an id");

endmodule

bind transaction_slot_table tst_checker u_tst_checker (.*);
